/* hw/rtl/shac_pkg.sv */
// Shared types and constants for the SHA-256 block compression core.
// No dependencies; imported by the round unit, the top level and the checker.
`default_nettype none

package shac_pkg;

    // Operation codes carried on the input channel.
    localparam logic OP_STATE = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Block geometry.
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned ROUNDS       = 64;
    localparam int unsigned WINDOW_WORDS = 16;
    localparam int unsigned DIGEST_BYTES = 32;

    // The eight working variables a..h of one round.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } shac_vars_t;

    // Standard SHA-256 round constants.
    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

/* hw/rtl/sha256_block_compress.sv */
// Top level of the SHA-256 block compression core: loading, sequencer and output.
// Depends on shac_pkg and shac_round.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    operation, state_word, data_byte
// out       source     out_valid / out_ready  hash_byte, last
//
// A state word or a message byte is accepted while the core is idle.
// The 64th byte starts the compression: 64 rounds through the single round
// unit, the final add to the chaining words, then 32 digest bytes at one per
// cycle while out_ready is high. The core is not ready for input from the
// 64th byte until the last digest byte is taken. A stalled output holds its
// byte. Reset clears only the counters and the sequencer.
`default_nettype none

module sha256_block_compress (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] state_word,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  hash_byte,
    output logic        last
);
    import shac_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FINAL = 4'b0100,
        ST_OUT   = 4'b1000
    } shac_state_t;

    localparam logic [5:0] LAST_BYTE_IDX  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LAST_ROUND_IDX = 6'(ROUNDS - 1);
    localparam logic [4:0] LAST_OUT_IDX   = 5'(DIGEST_BYTES - 1);
    localparam int unsigned WIN_BITS      = 32 * WINDOW_WORDS;

    shac_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  byte_cnt_reg, byte_cnt_next;
    logic [2:0]  state_idx_reg, state_idx_next;
    logic [4:0]  out_cnt_reg, out_cnt_next;

    logic [31:0]          chain_reg [8];
    logic [WIN_BITS-1:0]  win_reg;
    shac_vars_t           vars_reg;
    shac_vars_t           vars_next;
    logic [31:0]          w_new;
    logic [31:0]          out_word;
    logic                 in_fire;
    logic                 block_done;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign in_fire    = in_valid && in_ready;
    assign block_done = in_fire && (operation == OP_DATA) && (byte_cnt_reg == LAST_BYTE_IDX);

    // Shared round unit; the window holds W[t] .. W[t+15] with W[t] at the top.
    shac_round u_round (
        .vars      (vars_reg),
        .k         (ROUND_K[round_reg]),
        .w0        (win_reg[WIN_BITS-1 -: 32]),
        .w1        (win_reg[WIN_BITS-1-32 -: 32]),
        .w9        (win_reg[WIN_BITS-1-9*32 -: 32]),
        .w14       (win_reg[WIN_BITS-1-14*32 -: 32]),
        .vars_next (vars_next),
        .w_new     (w_new)
    );

    // Sequencer and counters.
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        byte_cnt_next  = byte_cnt_reg;
        state_idx_next = state_idx_reg;
        out_cnt_next   = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation == OP_STATE)
                    begin
                        state_idx_next = state_idx_reg + 3'd1;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 6'd1;
                        if (block_done)
                        begin
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND_IDX)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_idx_next = '0;
                out_cnt_next   = '0;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_cnt_next = out_cnt_reg + 5'd1;
                    if (out_cnt_reg == LAST_OUT_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            byte_cnt_reg  <= '0;
            state_idx_reg <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            byte_cnt_reg  <= byte_cnt_next;
            state_idx_reg <= state_idx_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    // Chaining words, message window and working variables.
    always_ff @(posedge clk)
    begin
        if (in_fire && (operation == OP_STATE))
        begin
            chain_reg[state_idx_reg] <= state_word;
        end
        if (in_fire && (operation == OP_DATA))
        begin
            win_reg <= {win_reg[WIN_BITS-9:0], data_byte};
        end
        if (block_done)
        begin
            vars_reg <= '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2], d: chain_reg[3],
                          e: chain_reg[4], f: chain_reg[5], g: chain_reg[6], h: chain_reg[7]};
        end
        if (state_reg == ST_ROUND)
        begin
            vars_reg <= vars_next;
            win_reg  <= {win_reg[WIN_BITS-33:0], w_new};
        end
        if (state_reg == ST_FINAL)
        begin
            chain_reg[0] <= chain_reg[0] + vars_reg.a;
            chain_reg[1] <= chain_reg[1] + vars_reg.b;
            chain_reg[2] <= chain_reg[2] + vars_reg.c;
            chain_reg[3] <= chain_reg[3] + vars_reg.d;
            chain_reg[4] <= chain_reg[4] + vars_reg.e;
            chain_reg[5] <= chain_reg[5] + vars_reg.f;
            chain_reg[6] <= chain_reg[6] + vars_reg.g;
            chain_reg[7] <= chain_reg[7] + vars_reg.h;
        end
    end

    // Digest byte: word from the upper count bits, most significant byte first.
    assign out_word  = chain_reg[out_cnt_reg[4:2]];
    assign hash_byte = out_word[{~out_cnt_reg[1:0], 3'b000} +: 8];
    assign last      = (out_cnt_reg == LAST_OUT_IDX);

endmodule

`default_nettype wire

/* hw/rtl/shac_round.sv */
// Combinational SHA-256 round unit: one compression round plus one schedule word.
// Depends on shac_pkg for the working-variable struct.
`default_nettype none

module shac_round (
    input  shac_pkg::shac_vars_t vars,
    input  logic [31:0]          k,
    input  logic [31:0]          w0,
    input  logic [31:0]          w1,
    input  logic [31:0]          w9,
    input  logic [31:0]          w14,
    output shac_pkg::shac_vars_t vars_next,
    output logic [31:0]          w_new
);
    import shac_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] bsig0;
    logic [31:0] bsig1;
    logic [31:0] ssig0;
    logic [31:0] ssig1;

    // Sigma functions of the round and of the schedule.
    assign bsig0 = rotr(vars.a, 2) ^ rotr(vars.a, 13) ^ rotr(vars.a, 22);
    assign bsig1 = rotr(vars.e, 6) ^ rotr(vars.e, 11) ^ rotr(vars.e, 25);
    assign ssig0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign ssig1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);

    // Choose and majority.
    assign ch  = (vars.e & vars.f) ^ (~vars.e & vars.g);
    assign maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);

    // Round temporaries; w0 is the schedule word of this round.
    assign t1 = vars.h + bsig1 + ch + k + w0;
    assign t2 = bsig0 + maj;

    // Schedule word sixteen rounds ahead of the current one.
    assign w_new = ssig1 + w9 + ssig0 + w0;

    // Rotate the working variables.
    always_comb
    begin
        vars_next.a = t1 + t2;
        vars_next.b = vars.a;
        vars_next.c = vars.b;
        vars_next.d = vars.c;
        vars_next.e = vars.d + t1;
        vars_next.f = vars.e;
        vars_next.g = vars.f;
        vars_next.h = vars.g;
    end

endmodule

`default_nettype wire

/* hw/rtl/shac_checker.sv */
// Port-level checker for the SHA-256 block compression core, with its bind.
// Depends on shac_pkg and on the ports of sha256_block_compress.
`default_nettype none

module shac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        operation,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  hash_byte,
    input logic        last
);
    import shac_pkg::*;

    // A stalled digest byte holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_byte) && $stable(last))
        else $error("digest byte changed while stalled");

    // The core never takes input while a digest is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during digest output");

    // The digest ends with the flagged byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid && in_ready)
        else $error("output continued after the last digest byte");

    // A chaining state word never starts a compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_STATE) |=> in_ready && !out_valid)
        else $error("state word left the core busy");

endmodule

bind sha256_block_compress shac_checker u_shac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_byte (hash_byte),
    .last      (last)
);

`default_nettype wire
